// File: hdl/sfe_pkg.sv
// shared types and constants for the spectral feature extractor
package sfe_pkg;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 18;

  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FFT_SIZE_LOG2 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROLLOFF_THRESHOLD = 2'd2;

  localparam logic [17:0] SAMPLE_RATE_RESET = 18'd44100;
  localparam logic [3:0] FFT_SIZE_LOG2_RESET = 4'd10;
  localparam logic [15:0] ROLLOFF_THRESHOLD_RESET = 16'd55706;

  localparam logic [25:0] SUM26_MAX = 26'h3FF_FFFF;
  localparam logic [35:0] SUM36_MAX = 36'hF_FFFF_FFFF;
  localparam logic [17:0] CENTROID_MAX = 18'd192000;

  localparam int DIV_NUM_W = 54;
  localparam int DIV_DEN_W = 41;
  localparam int DIV_QUO_W = 18;

  typedef struct packed {
    logic [15:0] magnitude;
    logic        last_bin;
  } in_word_t;

  typedef struct packed {
    logic [17:0] centroid_hz;
    logic [15:0] rolloff_fraction;
    logic [25:0] flux;
    logic [35:0] high_freq_content;
  } out_word_t;

endpackage

// File: hdl/sfe_div.sv
// restoring divider, one quotient bit per cycle, quotient known to fit
module sfe_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [sfe_pkg::DIV_NUM_W-1:0]  num,
  input  logic [sfe_pkg::DIV_DEN_W-1:0]  den,
  output logic                           done,
  output logic [sfe_pkg::DIV_QUO_W-1:0]  quo
);

  localparam int NW = sfe_pkg::DIV_NUM_W;
  localparam int QW = sfe_pkg::DIV_QUO_W;
  localparam int SW = sfe_pkg::DIV_DEN_W + QW - 1;
  localparam int CMW = (SW > NW) ? SW : NW;
  localparam int CNT_W = $clog2(QW);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [NW-1:0]    rem;
  logic [SW-1:0]    dsh;
  logic [QW-1:0]    q;
  logic             ge;
  logic [CMW-1:0]   diff;

  assign ge = CMW'(rem) >= CMW'(dsh);
  assign diff = CMW'(rem) - CMW'(dsh);
  assign quo = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CNT_W'(QW - 1);
        rem <= num;
        dsh <= {den, {(QW-1){1'b0}}};
        q <= '0;
      end else if (busy) begin
        if (ge) begin
          rem <= diff[NW-1:0];
        end
        q <= {q[QW-2:0], ge};
        dsh <= dsh >> 1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

endmodule

// File: hdl/spectral_feature_extractor_core.sv
// Spectral feature extractor: takes one magnitude bin per word and, on the word flagged
// last_bin, gives centroid, rolloff, flux and high-frequency content of the frame. After
// reset all MAX_BINS entries of the previous-spectrum memory are cleared, during which no
// word is taken. Each bin's previous value is read as the word is accepted and written
// back in the update state that follows, before the next word is taken. Closing a frame
// runs a two-step centroid multiply, a divide (skipped for a zero sum or a saturated
// centroid), a walk over stored bins up to the rolloff bin and a divide there if found. A
// finished result waits in an output register while the next frame loads.
module spectral_feature_extractor_core #(
  parameter int MAX_BINS = 1024,
  parameter int MAG_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  sfe_pkg::in_word_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output sfe_pkg::out_word_t                out_data,
  input  logic                              cfg_we,
  input  logic [sfe_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sfe_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int AW = $clog2(MAX_BINS);
  localparam int CW = $clog2(MAX_BINS + 1);
  localparam int MSW = ((MAG_BITS > 26) ? MAG_BITS : 26) + 1;
  localparam int PW = AW + MAG_BITS;
  localparam int WSW = ((PW > 36) ? PW : 36) + 1;
  localparam int RW = MAG_BITS + CW;
  localparam int CMPW = (RW + 16 > 42) ? RW + 16 : 42;

  typedef enum logic [10:0] {
    S_CLR    = 11'b00000000001,
    S_IDLE   = 11'b00000000010,
    S_UPD    = 11'b00000000100,
    S_MUL0   = 11'b00000001000,
    S_MUL1   = 11'b00000010000,
    S_CSTART = 11'b00000100000,
    S_CWAIT  = 11'b00001000000,
    S_RRD    = 11'b00010000000,
    S_RACC   = 11'b00100000000,
    S_RWAIT  = 11'b01000000000,
    S_DONE   = 11'b10000000000
  } state_t;

  state_t state;

  // configuration
  logic [17:0] sample_rate;
  logic [3:0]  fft_size_log2;
  logic [15:0] rolloff_threshold;

  // memories
  logic [MAG_BITS-1:0] prev_mem [MAX_BINS];
  logic [MAG_BITS-1:0] cur_mem [MAX_BINS];
  logic [MAG_BITS-1:0] prev_rd;
  logic [MAG_BITS-1:0] cur_rd;

  // accumulators
  logic [CW-1:0] bin_counter;
  logic [25:0]   magnitude_sum;
  logic [35:0]   weighted_sum;
  logic [25:0]   flux_sum;

  // latched item
  logic [MAG_BITS-1:0] mag;
  logic [AW-1:0]       idx;
  logic                last;
  logic                in_range;

  // frame close
  logic [25:0]   f_msum;
  logic [35:0]   f_wsum;
  logic [25:0]   f_flux;
  logic [CW-1:0] f_count;
  logic [41:0]   limit;
  logic [35:0]   p_lo;
  logic [35:0]   p_hi;
  logic [17:0]   centroid;
  logic [15:0]   rolloff;
  logic [AW-1:0] ri;
  logic [RW-1:0] running;

  logic [AW-1:0] clr_addr;
  logic          out_load;

  logic [MAG_BITS+15:0] mag_wide;
  logic [MSW-1:0]       msum_add;
  logic [25:0]          msum_next;
  logic [PW-1:0]        prod;
  logic [WSW-1:0]       wsum_add;
  logic [35:0]          wsum_next;
  logic [MAG_BITS-1:0]  diff;
  logic [MSW-1:0]       flux_add;
  logic [25:0]          flux_next;

  logic [sfe_pkg::DIV_NUM_W-1:0] c_num;
  logic [sfe_pkg::DIV_DEN_W-1:0] c_den;
  logic                          c_sat;
  logic [sfe_pkg::DIV_NUM_W-1:0] div_num;
  logic [sfe_pkg::DIV_DEN_W-1:0] div_den;
  logic                          div_start;
  logic                          div_done;
  logic [sfe_pkg::DIV_QUO_W-1:0] div_quo;

  logic [RW-1:0] running_next;
  logic          hit;

  assign in_stall = (state != S_IDLE);
  assign mag_wide = {{MAG_BITS{1'b0}}, in_data.magnitude};
  assign out_load = (state == S_DONE) && (!out_valid || !out_stall);

  always_comb begin
    msum_add = MSW'(magnitude_sum) + MSW'(mag);
    msum_next = (msum_add > MSW'(sfe_pkg::SUM26_MAX)) ? sfe_pkg::SUM26_MAX : msum_add[25:0];
    prod = PW'(idx) * PW'(mag);
    wsum_add = WSW'(weighted_sum) + WSW'(prod);
    wsum_next = (wsum_add > WSW'(sfe_pkg::SUM36_MAX)) ? sfe_pkg::SUM36_MAX : wsum_add[35:0];
    diff = (mag >= prev_rd) ? mag - prev_rd : prev_rd - mag;
    flux_add = MSW'(flux_sum) + MSW'(diff);
    flux_next = (flux_add > MSW'(sfe_pkg::SUM26_MAX)) ? sfe_pkg::SUM26_MAX : flux_add[25:0];
  end

  always_comb begin
    c_num = {p_hi, 18'd0} + {18'd0, p_lo};
    c_den = {15'd0, f_msum} << fft_size_log2;
    // a quotient of 2^18 or more is past the centroid range anyway
    c_sat = {5'd0, c_num[53:18]} >= c_den;
    running_next = running + RW'(cur_rd);
    hit = {running_next, 16'd0} > CMPW'(limit);
    div_start = 1'b0;
    div_num = c_num;
    div_den = c_den;
    if (state == S_CSTART) begin
      div_start = (f_msum != '0) && !c_sat;
    end else if (state == S_RACC) begin
      div_start = hit;
      div_num = sfe_pkg::DIV_NUM_W'({ri, 16'd0});
      div_den = sfe_pkg::DIV_DEN_W'(f_count);
    end
  end

  sfe_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // previous spectrum: cleared after reset, read at accept, written back in the next cycle
  always_ff @(posedge clk) begin
    if (state == S_CLR) begin
      prev_mem[clr_addr] <= '0;
    end else if (state == S_UPD && in_range) begin
      prev_mem[idx] <= mag;
    end
    prev_rd <= prev_mem[bin_counter[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (state == S_UPD && in_range) begin
      cur_mem[idx] <= mag;
    end
    cur_rd <= cur_mem[ri];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate <= sfe_pkg::SAMPLE_RATE_RESET;
      fft_size_log2 <= sfe_pkg::FFT_SIZE_LOG2_RESET;
      rolloff_threshold <= sfe_pkg::ROLLOFF_THRESHOLD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sfe_pkg::CFG_SAMPLE_RATE: sample_rate <= cfg_data;
        sfe_pkg::CFG_FFT_SIZE_LOG2: fft_size_log2 <= cfg_data[3:0];
        sfe_pkg::CFG_ROLLOFF_THRESHOLD: rolloff_threshold <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr_addr <= '0;
      bin_counter <= '0;
      magnitude_sum <= '0;
      weighted_sum <= '0;
      flux_sum <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(MAX_BINS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            mag <= mag_wide[MAG_BITS-1:0];
            last <= in_data.last_bin;
            idx <= bin_counter[AW-1:0];
            in_range <= bin_counter < CW'(MAX_BINS);
            state <= S_UPD;
          end
        end
        S_UPD: begin
          if (last) begin
            f_msum <= in_range ? msum_next : magnitude_sum;
            f_wsum <= in_range ? wsum_next : weighted_sum;
            f_flux <= in_range ? flux_next : flux_sum;
            f_count <= in_range ? bin_counter + 1'b1 : bin_counter;
            bin_counter <= '0;
            magnitude_sum <= '0;
            weighted_sum <= '0;
            flux_sum <= '0;
            state <= S_MUL0;
          end else begin
            if (in_range) begin
              magnitude_sum <= msum_next;
              weighted_sum <= wsum_next;
              flux_sum <= flux_next;
              bin_counter <= bin_counter + 1'b1;
            end
            state <= S_IDLE;
          end
        end
        S_MUL0: begin
          p_lo <= sample_rate * f_wsum[17:0];
          limit <= f_msum * rolloff_threshold;
          state <= S_MUL1;
        end
        S_MUL1: begin
          p_hi <= sample_rate * f_wsum[35:18];
          state <= S_CSTART;
        end
        S_CSTART: begin
          ri <= '0;
          running <= '0;
          if (f_msum == '0) begin
            centroid <= '0;
            state <= S_RRD;
          end else if (c_sat) begin
            centroid <= sfe_pkg::CENTROID_MAX;
            state <= S_RRD;
          end else begin
            state <= S_CWAIT;
          end
        end
        S_CWAIT: begin
          if (div_done) begin
            centroid <= (div_quo > sfe_pkg::CENTROID_MAX) ? sfe_pkg::CENTROID_MAX : div_quo;
            state <= S_RRD;
          end
        end
        S_RRD: begin
          state <= S_RACC;
        end
        S_RACC: begin
          running <= running_next;
          if (hit) begin
            state <= S_RWAIT;
          end else if (CW'(ri) + 1'b1 >= f_count) begin
            rolloff <= '0;
            state <= S_DONE;
          end else begin
            ri <= ri + 1'b1;
            state <= S_RRD;
          end
        end
        S_RWAIT: begin
          if (div_done) begin
            rolloff <= div_quo[15:0];
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_data.centroid_hz <= centroid;
            out_data.rolloff_fraction <= rolloff;
            out_data.flux <= f_flux;
            out_data.high_freq_content <= f_wsum;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
